// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Sizes, request and status codes, the per-cell command bundle and the key
// ranking function used by every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic insert;      // qualified insert (queue not full)
    logic remove;      // qualified remove (queue not empty)
    logic descending;  // current ordering
  } spq_cmd_t;

  // True when key a must stay behind key b
  function automatic logic ranks_after(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b,
                                       input logic descending);
    ranks_after = descending ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one (key, payload) pair; on insert it keeps, takes the new pair or
// takes its front neighbor's pair; on remove it takes its back neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                      clk,
  input  wire spq_pkg::spq_cmd_t         cmd,
  input  wire logic [spq_pkg::KEY_W-1:0] new_key,
  input  wire logic [spq_pkg::PAY_W-1:0] new_payload,
  input  wire logic [spq_pkg::KEY_W-1:0] prev_key,
  input  wire logic [spq_pkg::PAY_W-1:0] prev_payload,
  input  wire logic [spq_pkg::KEY_W-1:0] next_key,
  input  wire logic [spq_pkg::PAY_W-1:0] next_payload,
  input  wire logic                      occupied,
  input  wire logic                      pass_in,
  output logic                           pass_out,
  output logic [spq_pkg::KEY_W-1:0]      key_q,
  output logic [spq_pkg::PAY_W-1:0]      payload_q
);

  logic [spq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [spq_pkg::PAY_W-1:0] payload_r, payload_nxt;
  logic                      behind;

  // new pair goes past this slot only if it ranks after a stored pair
  assign behind   = occupied && spq_pkg::ranks_after(new_key, key_r, cmd.descending);
  assign pass_out = pass_in && behind;

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (cmd.insert) begin
      if (!pass_in) begin
        key_nxt     = prev_key;
        payload_nxt = prev_payload;
      end else if (!behind) begin
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end
    end else if (cmd.remove) begin
      key_nxt     = next_key;
      payload_nxt = next_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key_q     = key_r;
  assign payload_q = payload_r;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: sorted-list priority queue on a chain of cells
// Keeps up to DEPTH (key, payload) pairs in key order; insert, remove or read
// the front with one result per request.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy stays low, and each request's result
// appears on the out_ ports, marked by out_valid, in the cycle right after
// start; the receiver cannot stall and must take it then. The figure is set
// by the chain of DEPTH cells, which all update together at the accepting
// edge: each cell compares the new key against its own and a short AND chain
// from the front locates the insertion slot, while every cell behind it takes
// its neighbor's pair. Write the order register through cfg_ only while no
// request is in flight.
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [spq_pkg::ACT_W-1:0]  in_action,
  input  wire logic [spq_pkg::KEY_W-1:0]  in_new_key,
  input  wire logic [spq_pkg::PAY_W-1:0]  in_new_payload,
  // configuration channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_descending_order,
  // result channel
  output logic                            out_valid,
  output logic [spq_pkg::KEY_W-1:0]       out_front_key,
  output logic [spq_pkg::PAY_W-1:0]       out_front_payload,
  output logic [spq_pkg::CNT_W-1:0]       out_occupancy,
  output logic                            out_is_empty,
  output logic [spq_pkg::STAT_W-1:0]      out_status
);

  localparam int unsigned DEPTH = spq_pkg::DEPTH;
  localparam logic [spq_pkg::CNT_W-1:0] FULL_CNT = spq_pkg::CNT_W'(DEPTH);

  logic                          accept;
  logic                          full, empty;
  logic                          desc_r;
  logic [spq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [spq_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic                          out_valid_r;
  spq_pkg::spq_cmd_t             cmd;

  logic [spq_pkg::KEY_W-1:0]     cell_key [DEPTH];
  logic [spq_pkg::PAY_W-1:0]     cell_pay [DEPTH];
  logic [DEPTH:0]                pass;

  // Request acceptance: the chain updates at the accepting edge, so never hold off.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  // Decode the request; drop an insert when full and a remove when empty.
  always_comb begin
    cmd.insert     = 1'b0;
    cmd.remove     = 1'b0;
    cmd.descending = desc_r;
    count_nxt      = count_r;
    status_nxt     = spq_pkg::STAT_OK;
    if (accept) begin
      unique case (in_action)
        spq_pkg::ACT_INSERT: begin
          if (full) begin
            status_nxt = spq_pkg::STAT_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        spq_pkg::ACT_REMOVE: begin
          if (empty) begin
            status_nxt = spq_pkg::STAT_EMPTY;
          end else begin
            cmd.remove = 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        spq_pkg::ACT_READ, spq_pkg::ACT_SPARE: begin
          // read the front only; unused code behaves the same
        end
        default: begin
        end
      endcase
    end
  end

  // Control state: count, ordering register, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= spq_pkg::STAT_OK;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_descending_order;
      end
    end
  end

  // The chain: cell 0 is the front. The pass bit says that the new pair
  // ranks after every pair ahead of this cell, so the first cell that sees
  // pass high but does not push it on takes the new pair.
  assign pass[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [spq_pkg::KEY_W-1:0] prev_key, next_key;
    logic [spq_pkg::PAY_W-1:0] prev_pay, next_pay;
    logic                      occupied;

    if (i == 0) begin : g_front
      assign prev_key = '0;
      assign prev_pay = '0;
    end else begin : g_mid_prev
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      // hold the last slot on remove: it falls outside the count anyway
      assign next_key = cell_key[i];
      assign next_pay = cell_pay[i];
    end else begin : g_mid_next
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    assign occupied = (count_r > spq_pkg::CNT_W'(i));

    spq_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .new_key      (in_new_key),
      .new_payload  (in_new_payload),
      .prev_key     (prev_key),
      .prev_payload (prev_pay),
      .next_key     (next_key),
      .next_payload (next_pay),
      .occupied     (occupied),
      .pass_in      (pass[i]),
      .pass_out     (pass[i+1]),
      .key_q        (cell_key[i]),
      .payload_q    (cell_pay[i])
    );
  end

  // Result: state only changes on an accepted request, so present the front
  // cell and count directly during the strobe cycle; zero the pair when empty.
  assign out_valid         = out_valid_r;
  assign out_front_key     = empty ? '0 : cell_key[0];
  assign out_front_payload = empty ? '0 : cell_pay[0];
  assign out_occupancy     = count_r;
  assign out_is_empty      = empty;
  assign out_status        = status_r;

endmodule

`default_nettype wire
